// ===== rtl/core/hav_pkg.sv =====
// ----------------------------------------------------------------------------
// hav_pkg
// Shared constants, register codes and side-band types of the haversine
// angular distance pipeline.
// ----------------------------------------------------------------------------
package hav_pkg;

    // resolution of trig arguments, default
    localparam int ANGLE_BITS_DEF = 32;

    // series lengths
    localparam int SERIES_TERMS = 10;
    localparam int ATAN_TERMS   = 20;

    // fraction bits of the fixed-point formats
    localparam int FRAC_BITS = 30;

    // fixed-point constants
    localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
    localparam logic [30:0] HALF_Q30      = 31'h2000_0000;
    localparam logic [60:0] ONE_Q60       = 61'h1000_0000_0000_0000;
    localparam logic [30:0] HALFPI_Q30    = 31'd1686629713;
    localparam logic [30:0] QUARTERPI_Q30 = 31'd843314856;
    localparam logic [31:0] PI_Q30        = 32'd3373259426;
    localparam logic [31:0] RAD2DEG_K     = 32'd3845054675;
    localparam logic [31:0] DEG180_Q24    = 32'd3019898880;

    // register indexes on the configuration port
    localparam logic [1:0] REG_REF_RA  = 2'd0;
    localparam logic [1:0] REG_REF_DEC = 2'd1;
    localparam logic [1:0] REG_UNIT    = 2'd2;

    // side-band carried through the first divider
    typedef struct packed {
        logic zero;
        logic swapped;
    } t_div1_side;

    // side-band carried through the second divider
    typedef struct packed {
        logic        zero;
        logic        swapped;
        logic        big;
        logic [30:0] z;
    } t_div2_side;

    // side-band carried through the arctangent series
    typedef struct packed {
        logic zero;
        logic swapped;
        logic big;
    } t_atan_side;

    // magnitude of a signed Q30 value in [-1, 1]
    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] u;
        u = v[31] ? 32'(-v) : 32'(v);
        return u[30:0];
    endfunction

endpackage

// ===== rtl/core/hav_trig.sv =====
// ----------------------------------------------------------------------------
// hav_trig
// Pipelined sine and cosine of a 33-bit binary angle, Taylor series on the
// quadrant residual, signed Q30 results.
// ----------------------------------------------------------------------------
module hav_trig import hav_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [32:0]        i_phase,
    output logic               o_vld,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int DROP = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
    localparam logic [32:0] KEEP = ~((33'd1 << DROP) - 33'd1);
    localparam int NST = 3 * SERIES_TERMS;

    typedef struct packed {
        logic [1:0]         q;
        logic [31:0]        x2;
        logic [31:0]        ts;
        logic [31:0]        tc;
        logic [31:0]        qs;
        logic [31:0]        qc;
        logic signed [34:0] ss;
        logic signed [34:0] sc;
    } t_trig_st;

    logic [32:0] r_p;
    logic        r_p_vld;
    logic [30:0] r_x;
    logic [1:0]  r_x_q;
    logic        r_x_vld;
    t_trig_st    r_st  [0:NST];
    logic        r_vld [0:NST];
    logic signed [31:0] r_sin, r_cos;
    logic        r_o_vld;

    // input phase, low bits dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_phase & KEEP;
        end
    end

    // residual in radians
    logic [62:0] w_xp;
    assign w_xp = {r_p[30:0], 1'b0} * HALFPI_Q30;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else if (i_en) begin
            r_x_vld <= r_p_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= w_xp[62:32];
            r_x_q <= r_p[32:31];
        end
    end

    // square of the residual and first terms
    logic [61:0] w_x2p;
    t_trig_st    n_st0;
    always_comb begin
        w_x2p    = r_x * r_x;
        n_st0.q  = r_x_q;
        n_st0.x2 = w_x2p[61:30];
        n_st0.ts = {1'b0, r_x};
        n_st0.tc = {1'b0, ONE_Q30};
        n_st0.qs = '0;
        n_st0.qc = '0;
        n_st0.ss = $signed({4'b0, r_x});
        n_st0.sc = $signed({4'b0, ONE_Q30});
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_x_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_st0;
        end
    end

    // series terms: multiply, reciprocal estimate, correction and accumulate
    for (genvar j = 1; j <= NST; j++) begin : g_st
        localparam int K  = (j - 1) / 3 + 1;
        localparam int PH = (j - 1) % 3;
        localparam logic [31:0] DS = 32'((2 * K) * (2 * K + 1));
        localparam logic [31:0] DC = 32'((2 * K - 1) * (2 * K));
        localparam logic [32:0] RS = 33'((64'd1 << 32) / DS);
        localparam logic [32:0] RC = 33'((64'd1 << 32) / DC);

        t_trig_st    n_st;
        logic [63:0] w_ps, w_pc;
        logic [64:0] w_ms, w_mc;
        logic [31:0] w_rs, w_rc, w_qs, w_qc;

        always_comb begin
            w_ps = r_st[j-1].ts * r_st[j-1].x2;
            w_pc = r_st[j-1].tc * r_st[j-1].x2;
            w_ms = r_st[j-1].ts * RS;
            w_mc = r_st[j-1].tc * RC;
            w_rs = r_st[j-1].ts - r_st[j-1].qs * DS;
            w_rc = r_st[j-1].tc - r_st[j-1].qc * DC;
            w_qs = (w_rs >= DS) ? r_st[j-1].qs + 32'd1 : r_st[j-1].qs;
            w_qc = (w_rc >= DC) ? r_st[j-1].qc + 32'd1 : r_st[j-1].qc;
            n_st = r_st[j-1];
            if (PH == 0) begin
                n_st.ts = w_ps[61:30];
                n_st.tc = w_pc[61:30];
            end else if (PH == 1) begin
                n_st.qs = w_ms[63:32];
                n_st.qc = w_mc[63:32];
            end else begin
                n_st.ts = w_qs;
                n_st.tc = w_qc;
                if ((K % 2) == 1) begin
                    n_st.ss = r_st[j-1].ss - $signed({3'b0, w_qs});
                    n_st.sc = r_st[j-1].sc - $signed({3'b0, w_qc});
                end else begin
                    n_st.ss = r_st[j-1].ss + $signed({3'b0, w_qs});
                    n_st.sc = r_st[j-1].sc + $signed({3'b0, w_qc});
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= n_st;
            end
        end
    end

    // clamp to [0, 1] and unfold the quadrant
    logic [30:0] w_sx, w_cx;
    logic signed [31:0] n_sin, n_cos;
    always_comb begin
        if (r_st[NST].ss < 0) begin
            w_sx = '0;
        end else if (r_st[NST].ss > $signed({4'b0, ONE_Q30})) begin
            w_sx = ONE_Q30;
        end else begin
            w_sx = r_st[NST].ss[30:0];
        end
        if (r_st[NST].sc < 0) begin
            w_cx = '0;
        end else if (r_st[NST].sc > $signed({4'b0, ONE_Q30})) begin
            w_cx = ONE_Q30;
        end else begin
            w_cx = r_st[NST].sc[30:0];
        end
        unique case (r_st[NST].q)
            2'd0: begin
                n_sin = $signed({1'b0, w_sx});
                n_cos = $signed({1'b0, w_cx});
            end
            2'd1: begin
                n_sin = $signed({1'b0, w_cx});
                n_cos = -$signed({1'b0, w_sx});
            end
            2'd2: begin
                n_sin = -$signed({1'b0, w_sx});
                n_cos = -$signed({1'b0, w_cx});
            end
            default: begin
                n_sin = -$signed({1'b0, w_cx});
                n_cos = $signed({1'b0, w_sx});
            end
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[NST];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_vld = r_o_vld;
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== rtl/core/hav_isqrt.sv =====
// ----------------------------------------------------------------------------
// hav_isqrt
// Pipelined floor square root of a Q60 value in [0, 1], one result bit per
// stage, Q30 result.
// ----------------------------------------------------------------------------
module hav_isqrt import hav_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [60:0] i_n,
    output logic        o_vld,
    output logic [30:0] o_root
);

    localparam int NST = 31;

    logic [61:0] r_n   [0:NST];
    logic [61:0] r_r   [0:NST];
    logic        r_vld [0:NST];

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= {1'b0, i_n};
            r_r[0] <= '0;
        end
    end

    // one digit of the root per stage
    for (genvar i = 1; i <= NST; i++) begin : g_st
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * (i - 1));
        logic [61:0] w_trial, n_n, n_r;
        always_comb begin
            w_trial = r_r[i-1] + BIT;
            if (r_n[i-1] >= w_trial) begin
                n_n = r_n[i-1] - w_trial;
                n_r = (r_r[i-1] >> 1) + BIT;
            end else begin
                n_n = r_n[i-1];
                n_r = r_r[i-1] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[i] <= n_n;
                r_r[i] <= n_r;
            end
        end
    end

    assign o_vld  = r_vld[NST];
    assign o_root = r_r[NST][30:0];

endmodule

// ===== rtl/core/hav_div.sv =====
// ----------------------------------------------------------------------------
// hav_div
// Pipelined restoring divider for a fraction num / den with num <= den,
// one quotient bit per stage, side-band carried along.
// ----------------------------------------------------------------------------
module hav_div import hav_pkg::*; #(
    parameter int SIDE_W = 2,
    parameter int FRAC   = FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [FRAC:0]     o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic [31:0]       r_num;
    logic [31:0]       r_den0;
    logic [SIDE_W-1:0] r_side0;
    logic              r_vld0;

    logic [31:0]       r_rem  [0:FRAC];
    logic [FRAC:0]     r_q    [0:FRAC];
    logic [31:0]       r_den  [0:FRAC];
    logic [SIDE_W-1:0] r_side [0:FRAC];
    logic              r_vld  [0:FRAC];

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= i_num;
            r_den0  <= i_den;
            r_side0 <= i_side;
        end
    end

    // integer bit of the quotient
    logic w_top;
    assign w_top = (r_num >= r_den0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_vld0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_top ? r_num - r_den0 : r_num;
            r_q[0]    <= {{FRAC{1'b0}}, w_top};
            r_den[0]  <= r_den0;
            r_side[0] <= r_side0;
        end
    end

    // fraction bits
    for (genvar s = 1; s <= FRAC; s++) begin : g_st
        logic [32:0] w_sh;
        logic        w_ge;
        assign w_sh = {r_rem[s-1], 1'b0};
        assign w_ge = (w_sh >= {1'b0, r_den[s-1]});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? 32'(w_sh - {1'b0, r_den[s-1]}) : w_sh[31:0];
                r_q[s]    <= {r_q[s-1][FRAC-1:0], w_ge};
                r_den[s]  <= r_den[s-1];
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_vld  = r_vld[FRAC];
    assign o_quot = r_q[FRAC];
    assign o_side = r_side[FRAC];

endmodule

// ===== rtl/core/hav_atan.sv =====
// ----------------------------------------------------------------------------
// hav_atan
// Pipelined arctangent of a Q30 argument in [0, 0.5] by alternating power
// series, side-band carried along.
// ----------------------------------------------------------------------------
module hav_atan import hav_pkg::*; #(
    parameter int SIDE_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [31:0]       i_arg,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [30:0]       o_atan,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NST = 2 * ATAN_TERMS;

    typedef struct packed {
        logic [31:0]        w2;
        logic [31:0]        p;
        logic [31:0]        pn;
        logic [31:0]        qs;
        logic signed [33:0] sum;
    } t_atan_st;

    logic [31:0]       r_w;
    logic [SIDE_W-1:0] r_side0;
    logic              r_vld0;
    t_atan_st          r_st   [0:NST];
    logic [SIDE_W-1:0] r_side [0:NST];
    logic              r_vld  [0:NST];
    logic [30:0]       r_atan;
    logic [SIDE_W-1:0] r_o_side;
    logic              r_o_vld;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w     <= i_arg;
            r_side0 <= i_side;
        end
    end

    // square of the argument
    logic [63:0] w_w2p;
    t_atan_st    n_st0;
    always_comb begin
        w_w2p     = r_w * r_w;
        n_st0.w2  = w_w2p[61:30];
        n_st0.p   = r_w;
        n_st0.pn  = '0;
        n_st0.qs  = '0;
        n_st0.sum = '0;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= r_vld0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]   <= n_st0;
            r_side[0] <= r_side0;
        end
    end

    // series terms: next power and reciprocal estimate, then correction
    for (genvar j = 1; j <= NST; j++) begin : g_st
        localparam int K  = (j - 1) / 2;
        localparam int PH = (j - 1) % 2;
        localparam logic [31:0] D = 32'(2 * K + 1);
        localparam logic [32:0] R = 33'((64'd1 << 32) / D);

        t_atan_st    n_st;
        logic [63:0] w_pp;
        logic [64:0] w_m;
        logic [31:0] w_r, w_q;

        always_comb begin
            w_pp = r_st[j-1].p * r_st[j-1].w2;
            w_m  = r_st[j-1].p * R;
            w_r  = r_st[j-1].p - r_st[j-1].qs * D;
            w_q  = (w_r >= D) ? r_st[j-1].qs + 32'd1 : r_st[j-1].qs;
            n_st = r_st[j-1];
            if (PH == 0) begin
                n_st.qs = w_m[63:32];
                n_st.pn = w_pp[61:30];
            end else begin
                n_st.p = r_st[j-1].pn;
                if ((K % 2) == 1) begin
                    n_st.sum = r_st[j-1].sum - $signed({2'b0, w_q});
                end else begin
                    n_st.sum = r_st[j-1].sum + $signed({2'b0, w_q});
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j]   <= n_st;
                r_side[j] <= r_side[j-1];
            end
        end
    end

    // negative sum reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[NST];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_atan   <= (r_st[NST].sum < 0) ? 31'd0 : r_st[NST].sum[30:0];
            r_o_side <= r_side[NST];
        end
    end

    assign o_vld  = r_o_vld;
    assign o_atan = r_atan;
    assign o_side = r_o_side;

endmodule

// ===== rtl/core/haversine_angular_distance.sv =====
// ----------------------------------------------------------------------------
// haversine_angular_distance
// Great-circle distance of each streamed star from a configured reference
// point by the haversine formula, in radians Q2.30 or degrees Q8.24.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  star      in         i_valid / o_stall   i_star_ra, i_star_dec
//  result    out        o_valid / i_stall   o_separation
//  config    in/out     apb write/read      paddr, pwdata, prdata
//
//  one word enters per clock while o_stall is low; each result passes the
//  series stages, the two square roots and the two dividers before it leaves.
//  synchronous active-low reset clears the valid bits and the configuration registers.
//  a stall at the output freezes the whole pipeline; o_stall follows it in
//  the same cycle, so no word is dropped or repeated.
// ----------------------------------------------------------------------------
module haversine_angular_distance import hav_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_star_ra,
    input  logic signed [31:0] i_star_dec,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_separation
);

    logic [31:0] r_ref_ra;
    logic [31:0] r_ref_dec;
    logic        r_unit;
    logic        w_en;
    logic        r_out_vld;
    logic [31:0] r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_ra  <= '0;
            r_ref_dec <= '0;
            r_unit    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_REF_RA:  r_ref_ra  <= pwdata;
                REG_REF_DEC: r_ref_dec <= pwdata;
                REG_UNIT:    r_unit    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[3:2])
            REG_REF_RA:  prdata = r_ref_ra;
            REG_REF_DEC: prdata = r_ref_dec;
            REG_UNIT:    prdata = {31'd0, r_unit};
            default:     prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // pipeline advances unless a result is held by the sink
    assign w_en    = !r_out_vld || !i_stall;
    assign o_stall = !w_en;

    // half-angle phases, 2^33 a full turn
    logic [32:0] w_p_ra, w_p_dec, w_p_cref, w_p_cstar;
    assign w_p_ra    = {1'b0, 32'(r_ref_ra - i_star_ra)};
    assign w_p_dec   = {r_ref_dec[31], r_ref_dec} - {i_star_dec[31], i_star_dec};
    assign w_p_cref  = {r_ref_dec, 1'b0};
    assign w_p_cstar = {i_star_dec, 1'b0};

    logic               w_trig_vld;
    logic signed [31:0] w_s_ra, w_s_dec, w_c_ref, w_c_star;

    hav_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_ra (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_valid),
        .i_phase(w_p_ra), .o_vld(w_trig_vld), .o_sin(w_s_ra), .o_cos()
    );
    hav_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_dec (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_valid),
        .i_phase(w_p_dec), .o_vld(), .o_sin(w_s_dec), .o_cos()
    );
    hav_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_cref (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_valid),
        .i_phase(w_p_cref), .o_vld(), .o_sin(), .o_cos(w_c_ref)
    );
    hav_trig #(.ANGLE_BITS(ANGLE_BITS)) u_trig_cstar (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_valid),
        .i_phase(w_p_cstar), .o_vld(), .o_sin(), .o_cos(w_c_star)
    );

    // declination term and cosine product
    logic [30:0] w_msra, w_msdec, w_mcr, w_mcs;
    logic [61:0] w_a1p, w_cmp;
    logic        r1_vld, r1_neg;
    logic [60:0] r1_a1;
    logic [30:0] r1_cm, r1_msra;
    always_comb begin
        w_msra  = mag31(w_s_ra);
        w_msdec = mag31(w_s_dec);
        w_mcr   = mag31(w_c_ref);
        w_mcs   = mag31(w_c_star);
        w_a1p   = w_msdec * w_msdec;
        w_cmp   = w_mcr * w_mcs;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= w_trig_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a1   <= w_a1p[60:0];
            r1_cm   <= w_cmp[60:30];
            r1_neg  <= w_c_ref[31] != w_c_star[31];
            r1_msra <= w_msra;
        end
    end

    // cosine product times sine of half RA difference
    logic [61:0] w_tp;
    logic        r2_vld, r2_neg;
    logic [60:0] r2_a1;
    logic [30:0] r2_t, r2_msra;
    assign w_tp = r1_cm * r1_msra;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a1   <= r1_a1;
            r2_neg  <= r1_neg;
            r2_t    <= w_tp[60:30];
            r2_msra <= r1_msra;
        end
    end

    // second factor of the RA term
    logic [61:0] w_a2p;
    logic        r3_vld, r3_neg;
    logic [60:0] r3_a1, r3_a2;
    assign w_a2p = r2_t * r2_msra;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a1  <= r2_a1;
            r3_a2  <= w_a2p[60:0];
            r3_neg <= r2_neg;
        end
    end

    // haversine sum clamped to [0, 1]
    logic signed [62:0] w_suma;
    logic [60:0]        w_a, w_na;
    always_comb begin
        if (r3_neg) begin
            w_suma = $signed({2'b0, r3_a1}) - $signed({2'b0, r3_a2});
        end else begin
            w_suma = $signed({2'b0, r3_a1}) + $signed({2'b0, r3_a2});
        end
        if (w_suma[62]) begin
            w_a = '0;
        end else if (w_suma[61:0] > {1'b0, ONE_Q60}) begin
            w_a = ONE_Q60;
        end else begin
            w_a = w_suma[60:0];
        end
        w_na = ONE_Q60 - w_a;
    end

    logic        w_sq_vld;
    logic [30:0] w_sroot, w_croot;
    hav_isqrt u_sqrt_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r3_vld),
        .i_n(w_a), .o_vld(w_sq_vld), .o_root(w_sroot)
    );
    hav_isqrt u_sqrt_na (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r3_vld),
        .i_n(w_na), .o_vld(), .o_root(w_croot)
    );

    // order the roots so the ratio stays within [0, 1]
    t_div1_side  w_s1_in, w_s1_out;
    logic [31:0] w_num1, w_den1;
    always_comb begin
        w_s1_in.zero    = (w_sroot == '0) && (w_croot == '0);
        w_s1_in.swapped = w_sroot > w_croot;
        w_num1 = {1'b0, w_s1_in.swapped ? w_croot : w_sroot};
        w_den1 = {1'b0, w_s1_in.swapped ? w_sroot : w_croot};
    end

    logic        w_d1_vld;
    logic [30:0] w_z;
    hav_div #(.SIDE_W($bits(t_div1_side))) u_div_ratio (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(w_sq_vld),
        .i_num(w_num1), .i_den(w_den1), .i_side(w_s1_in),
        .o_vld(w_d1_vld), .o_quot(w_z), .o_side(w_s1_out)
    );

    // argument reduction (1 - z) / (1 + z) for ratios above one half
    t_div2_side  w_s2_in, w_s2_out;
    logic [31:0] w_num2, w_den2;
    always_comb begin
        w_s2_in.zero    = w_s1_out.zero;
        w_s2_in.swapped = w_s1_out.swapped;
        w_s2_in.big     = w_z > HALF_Q30;
        w_s2_in.z       = w_z;
        w_num2 = {1'b0, ONE_Q30} - {1'b0, w_z};
        w_den2 = {1'b0, ONE_Q30} + {1'b0, w_z};
    end

    logic        w_d2_vld;
    logic [30:0] w_w;
    hav_div #(.SIDE_W($bits(t_div2_side))) u_div_reduce (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(w_d1_vld),
        .i_num(w_num2), .i_den(w_den2), .i_side(w_s2_in),
        .o_vld(w_d2_vld), .o_quot(w_w), .o_side(w_s2_out)
    );

    // series argument
    t_atan_side  w_s3_in, w_s3_out;
    logic [31:0] w_arg;
    always_comb begin
        w_s3_in.zero    = w_s2_out.zero;
        w_s3_in.swapped = w_s2_out.swapped;
        w_s3_in.big     = w_s2_out.big;
        w_arg = {1'b0, w_s2_out.big ? w_w : w_s2_out.z};
    end

    logic        w_at_vld;
    logic [30:0] w_at;
    hav_atan #(.SIDE_W($bits(t_atan_side))) u_atan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(w_d2_vld),
        .i_arg(w_arg), .i_side(w_s3_in),
        .o_vld(w_at_vld), .o_atan(w_at), .o_side(w_s3_out)
    );

    // fold back to the first quadrant and double
    logic [30:0] w_r, w_rc, w_res;
    logic [31:0] w_rad;
    logic        r_f1_vld;
    logic [31:0] r_f1_rad;
    always_comb begin
        if (w_s3_out.big) begin
            w_r = (w_at > QUARTERPI_Q30) ? 31'd0 : QUARTERPI_Q30 - w_at;
        end else begin
            w_r = w_at;
        end
        w_rc  = (w_r > HALFPI_Q30) ? HALFPI_Q30 : w_r;
        w_res = w_s3_out.swapped ? HALFPI_Q30 - w_rc : w_rc;
        if (w_s3_out.zero) begin
            w_res = '0;
        end
        w_rad = {w_res, 1'b0};
        if (w_rad > PI_Q30) begin
            w_rad = PI_Q30;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= w_at_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_rad <= w_rad;
        end
    end

    // conversion to degrees
    logic [63:0] w_degp;
    logic        r_f2_vld;
    logic [31:0] r_f2_rad, r_f2_deg;
    assign w_degp = r_f1_rad * RAD2DEG_K;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_vld <= 1'b0;
        end else if (w_en) begin
            r_f2_vld <= r_f1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2_rad <= r_f1_rad;
            r_f2_deg <= w_degp[63:32];
        end
    end

    // output register, unit select
    logic [31:0] n_out;
    always_comb begin
        if (r_unit) begin
            n_out = (r_f2_deg > DEG180_Q24) ? DEG180_Q24 : r_f2_deg;
        end else begin
            n_out = r_f2_rad;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_f2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_separation = r_out;

endmodule

// ===== tb/haversine_angular_distance_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haversine_angular_distance_tb
// Streams star positions through the haversine pipeline under several
// reference points and both output units. A fixed-point model of the
// formula computes the separation of every accepted word. A monitor
// compares the results in order, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module haversine_angular_distance_tb;
    import hav_pkg::*;

    localparam int  ANGLE      = 32;
    localparam int  DROP       = (ANGLE < 32) ? 32 - ANGLE : 0;
    localparam int  CYC_LIMIT  = 600000;
    localparam int  TAIL       = 260;
    localparam int  PHASE_LEN  = 100;
    localparam int  NUM_PHASES = 8;
    localparam longint unsigned K_ONE30 = 64'd1 << 30;
    localparam longint unsigned K_ONE60 = 64'd1 << 60;

    typedef struct {
        logic [31:0] ra;
        logic [31:0] dec;
    } t_star;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_star_ra;
    logic signed [31:0] i_star_dec;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_separation;

    // configuration copy used by the predictor
    logic [31:0] cfg_ra;
    logic [31:0] cfg_dec;
    logic        cfg_deg;

    t_star       star_queue[$];
    logic [31:0] sep_expected[$];
    int          errors;
    int          cycles;
    int          words_in;
    int          words_out;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          mode_left;

    haversine_angular_distance u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_star_ra   (i_star_ra),
        .i_star_dec  (i_star_dec),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_separation(o_separation)
    );

    // sin and cos of a 33-bit binary angle, signed Q30
    function automatic void sincos33(input logic [32:0] ang, output longint s_o,
                                     output longint c_o);
        logic [32:0]     p;
        logic [1:0]      q;
        longint unsigned f, x, x2, term;
        longint          sx, cx;
        p  = ang & ~((33'd1 << DROP) - 33'd1);
        q  = p[32:31];
        f  = {32'd0, p[30:0], 1'b0};
        x  = (f * 64'(HALFPI_Q30)) >> 32;
        x2 = (x * x) >> 30;
        term = x;
        sx   = longint'(x);
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k & 1) sx -= longint'(term); else sx += longint'(term);
        end
        term = K_ONE30;
        cx   = longint'(K_ONE30);
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k & 1) cx -= longint'(term); else cx += longint'(term);
        end
        if (sx < 0) sx = 0;
        if (sx > longint'(K_ONE30)) sx = longint'(K_ONE30);
        if (cx < 0) cx = 0;
        if (cx > longint'(K_ONE30)) cx = longint'(K_ONE30);
        case (q)
            2'd0: begin s_o = sx;  c_o = cx;  end
            2'd1: begin s_o = cx;  c_o = -sx; end
            2'd2: begin s_o = -sx; c_o = -cx; end
            default: begin s_o = -cx; c_o = sx; end
        endcase
    endfunction

    function automatic longint unsigned absval(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // floor square root
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r, b, m;
        r = 0;
        b = 64'd1 << 62;
        m = n;
        while (b > m) b >>= 2;
        while (b != 0) begin
            if (m >= r + b) begin
                m = m - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // arctangent series for arguments up to one half
    function automatic longint unsigned atan_series(input longint unsigned w);
        longint unsigned w2, p, t;
        longint          sum;
        w2  = (w * w) >> 30;
        p   = w;
        sum = 0;
        for (int k = 0; k < ATAN_TERMS; k++) begin
            t = p / longint'(2 * k + 1);
            if (k & 1) sum -= longint'(t); else sum += longint'(t);
            p = (p * w2) >> 30;
        end
        return (sum < 0) ? 0 : longint'(sum);
    endfunction

    // first-quadrant atan2 in Q30 radians
    function automatic longint unsigned atan2_quad(input longint unsigned y,
                                                   input longint unsigned x);
        longint unsigned num, den, z, r, w, t;
        logic            swp;
        if (x == 0 && y == 0) return 0;
        swp = y > x;
        num = swp ? x : y;
        den = swp ? y : x;
        z   = (num << 30) / den;
        if (z > (K_ONE30 >> 1)) begin
            w = ((K_ONE30 - z) << 30) / (K_ONE30 + z);
            t = atan_series(w);
            r = (t > 64'(QUARTERPI_Q30)) ? 0 : 64'(QUARTERPI_Q30) - t;
        end else begin
            r = atan_series(z);
        end
        if (r > 64'(HALFPI_Q30)) r = 64'(HALFPI_Q30);
        return swp ? 64'(HALFPI_Q30) - r : r;
    endfunction

    // separation of one star from the configured reference point
    function automatic logic [31:0] haversine_sep(input t_star st);
        logic [31:0]     dra;
        logic [32:0]     ddec;
        longint          s_ra, s_dec, c_ref, c_star, unused;
        longint unsigned a1, a2, cm, a, sroot, croot, rad, res;
        longint          suma;
        logic            neg;
        dra  = cfg_ra - st.ra;
        ddec = 33'(longint'($signed(cfg_dec)) - longint'($signed(st.dec)));
        sincos33({1'b0, dra}, s_ra, unused);
        sincos33(ddec, s_dec, unused);
        sincos33({cfg_dec, 1'b0}, unused, c_ref);
        sincos33({st.dec, 1'b0}, unused, c_star);
        a1   = absval(s_dec) * absval(s_dec);
        cm   = (absval(c_ref) * absval(c_star)) >> 30;
        neg  = (c_ref < 0) != (c_star < 0);
        a2   = ((cm * absval(s_ra)) >> 30) * absval(s_ra);
        suma = neg ? longint'(a1) - longint'(a2) : longint'(a1) + longint'(a2);
        if (suma < 0) suma = 0;
        a = longint'(suma);
        if (a > K_ONE60) a = K_ONE60;
        sroot = floor_sqrt(a);
        croot = floor_sqrt(K_ONE60 - a);
        rad   = 2 * atan2_quad(sroot, croot);
        if (rad > 64'(PI_Q30)) rad = 64'(PI_Q30);
        if (cfg_deg) begin
            res = (rad * 64'(RAD2DEG_K)) >> 32;
            if (res > 64'(DEG180_Q24)) res = 64'(DEG180_Q24);
        end else begin
            res = rad;
        end
        return res[31:0];
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // register write, setup then access
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REF_RA:  cfg_ra  = val;
            REG_REF_DEC: cfg_dec = val;
            REG_UNIT:    cfg_deg = val[0];
            default: ;
        endcase
    endtask

    function automatic t_star mk_star(input logic [31:0] ra, input logic [31:0] dec);
        t_star st;
        st.ra  = ra;
        st.dec = dec;
        return st;
    endfunction

    // random star, mostly legal declinations, some with any bit pattern
    function automatic t_star rand_star();
        logic [31:0] dec;
        if ($urandom_range(0, 5) == 0) dec = $urandom();
        else dec = 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        return mk_star($urandom(), dec);
    endfunction

    task automatic wait_drained();
        @(posedge i_clk);
        while (star_queue.size() != 0 || i_valid || sep_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // stimulus and phase sequencing
    initial begin
        logic [31:0] ra_set, dec_set;
        errors  = 0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cfg_ra  = '0;
        cfg_dec = '0;
        cfg_deg = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at reset configuration (reference at origin, radians)
        star_queue.push_back(mk_star(32'h0, 32'h0));             // zero distance
        star_queue.push_back(mk_star(32'h8000_0000, 32'h0));     // antipode
        star_queue.push_back(mk_star(32'h0, 32'h4000_0000));     // north pole
        star_queue.push_back(mk_star(32'h1234_5678, 32'hC000_0000)); // south pole
        star_queue.push_back(mk_star(32'hFFFF_FFFF, 32'h0));     // ra wrap
        star_queue.push_back(mk_star(32'h0000_0001, 32'hFFFF_FFFF));
        star_queue.push_back(mk_star(32'h4000_0000, 32'h2000_0000));
        star_queue.push_back(mk_star(32'h8000_0000, 32'h7FFF_FFFF)); // dec out of range
        star_queue.push_back(mk_star(32'h7FFF_FFFF, 32'h8000_0000));
        star_queue.push_back(mk_star(32'h8000_0001, 32'h0000_0001));
        star_queue.push_back(mk_star(32'hC000_0000, 32'h4000_0001));
        star_queue.push_back(mk_star(32'h8000_0000, 32'h8000_0001));
        wait_drained();

        // directed words in degrees, reference at a pole, saturation near 180
        reg_write(REG_UNIT, 32'h1);
        reg_write(REG_REF_DEC, 32'h4000_0000);
        reg_write(REG_REF_RA, 32'hFFFF_FFFF);
        star_queue.push_back(mk_star(32'h0, 32'hC000_0000));
        star_queue.push_back(mk_star(32'h7FFF_FFFF, 32'h4000_0000));
        star_queue.push_back(mk_star(32'h8000_0000, 32'hC000_0001));
        star_queue.push_back(mk_star(32'hFFFF_FFFF, 32'h0));
        star_queue.push_back(mk_star(32'h0, 32'hFFFF_FFFF));
        star_queue.push_back(mk_star(32'h8000_0000, 32'h8000_0000));
        wait_drained();

        // random phases, extremes of the reference first
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin ra_set = 32'h0;         dec_set = 32'hC000_0000; end
                1: begin ra_set = 32'hFFFF_FFFF; dec_set = 32'h4000_0000; end
                2: begin ra_set = $urandom();    dec_set = 32'h0;         end
                3: begin ra_set = $urandom();    dec_set = $urandom();    end
                default: begin
                    ra_set  = $urandom();
                    dec_set = 32'($signed($urandom_range(0, 32'h8000_0000))
                              - 32'sh4000_0000);
                end
            endcase
            reg_write(REG_REF_RA, ra_set);
            reg_write(REG_REF_DEC, dec_set);
            reg_write(REG_UNIT, 32'(ph & 1));
            for (int n = 0; n < PHASE_LEN; n++) begin
                // some stars right at or opposite the reference
                if ($urandom_range(0, 9) == 0)
                    star_queue.push_back(mk_star(ra_set ^ ($urandom_range(0, 1) << 31),
                                                 dec_set));
                else
                    star_queue.push_back(rand_star());
            end
            wait_drained();
        end

        repeat (TAIL) @(posedge i_clk);
        if (sep_expected.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sep_expected.size());
            errors++;
        end
        $display("sent %0d star words, checked %0d separations over %0d reference settings",
                 words_in, words_out, NUM_PHASES + 2);
        if (errors == 0) begin
            $display("haversine_angular_distance_tb: clean");
        end else begin
            $display("haversine_angular_distance_tb: errors");
        end
        $finish;
    end

    // star word driver, bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_star_ra  <= '0;
            i_star_dec <= '0;
            words_in   <= 0;
            burst_left <= $urandom_range(1, 40);
            gap_left   <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                sep_expected.push_back(haversine_sep(mk_star(i_star_ra, i_star_dec)));
                words_in <= words_in + 1;
            end
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (star_queue.size() != 0) begin
                t_star st;
                st = star_queue.pop_front();
                i_valid    <= 1'b1;
                i_star_ra  <= st.ra;
                i_star_dec <= st.dec;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: none, random, or long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_mode <= 0;
            mode_left  <= 50;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 2) == 0);
                default: i_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            words_out <= 0;
        end else if (o_valid && !i_stall) begin
            if (sep_expected.size() == 0) begin
                $display("%0t: unexpected separation %h", $time, o_separation);
                errors++;
            end else begin
                logic [31:0] want;
                want = sep_expected.pop_front();
                if (o_separation !== want) begin
                    $display("%0t: separation expected %h actual %h",
                             $time, want, o_separation);
                    errors++;
                end
            end
            words_out <= words_out + 1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycles <= 0;
        end else begin
            cycles <= cycles + 1;
            if (cycles > CYC_LIMIT) begin
                $display("haversine_angular_distance_tb: errors");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
rtl/core/hav_pkg.sv
rtl/core/hav_trig.sv
rtl/core/hav_isqrt.sv
rtl/core/hav_div.sv
rtl/core/hav_atan.sv
rtl/core/haversine_angular_distance.sv
tb/haversine_angular_distance_tb.sv
